FILE: sv/mbe_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time pixel block
package mbe_pkg;

  // Field widths
  localparam int COORD_BITS   = 12;
  localparam int COORD_W      = 32;  // signed Q4.28
  localparam int STEP_W       = 31;  // unsigned Q3.28
  localparam int ITER_W       = 16;
  localparam int COLOR_W      = 8;
  localparam int PALETTE_SIZE = 16;
  localparam int PAL_IDX_W    = $clog2(PALETTE_SIZE);
  localparam int FRAC_BITS    = 28;
  localparam int PROD_W       = 2 * COORD_W;
  localparam int WIDE_W       = 48;  // headroom for every intermediate sum

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LEFT   = 3'd0,
    CFG_Y_TOP    = 3'd1,
    CFG_STEP_X   = 3'd2,
    CFG_STEP_Y   = 3'd3,
    CFG_MAX_ITER = 3'd4
  } cfg_reg_e;

  // Register reset values
  localparam logic signed [COORD_W-1:0] X_LEFT_RST   = -32'sd671088640;
  localparam logic signed [COORD_W-1:0] Y_TOP_RST    = -32'sd268435456;
  localparam logic [STEP_W-1:0]         STEP_X_RST   = 31'd1468006;
  localparam logic [STEP_W-1:0]         STEP_Y_RST   = 31'd1118481;
  localparam logic [ITER_W-1:0]         MAX_ITER_RST = 16'd128;

  // Escape radius squared, 4.0 in Q4.28
  localparam logic signed [WIDE_W-1:0] ESCAPE_LIMIT = 48'sd1 <<< (FRAC_BITS + 2);

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 48'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -48'sd2147483648;

  // Palette, packed as {red, green, blue}
  localparam logic [3*COLOR_W-1:0] PALETTE [PALETTE_SIZE] = '{
    {8'd66,  8'd30,  8'd15 }, {8'd25,  8'd7,   8'd26 },
    {8'd9,   8'd1,   8'd47 }, {8'd4,   8'd4,   8'd73 },
    {8'd0,   8'd7,   8'd100}, {8'd12,  8'd44,  8'd138},
    {8'd24,  8'd82,  8'd177}, {8'd57,  8'd125, 8'd209},
    {8'd134, 8'd181, 8'd229}, {8'd211, 8'd236, 8'd248},
    {8'd241, 8'd233, 8'd191}, {8'd248, 8'd201, 8'd95 },
    {8'd255, 8'd170, 8'd0  }, {8'd204, 8'd128, 8'd0  },
    {8'd153, 8'd87,  8'd0  }, {8'd106, 8'd52,  8'd3  }
  };

  // Controller state
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_pix;
    logic load_c;
    logic mul;
    logic upd;
    logic push;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cap_hit;
    logic escaped;
  } status_t;

  // Clamp a wide signed value into the signed 32-bit range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/mbe_pix_if.sv
// Pixel coordinate channel
interface mbe_pix_if;
  logic                            valid;
  logic                            ready;
  logic [mbe_pkg::COORD_BITS-1:0]  pixel_col;
  logic [mbe_pkg::COORD_BITS-1:0]  pixel_row;

  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

FILE: sv/mbe_res_if.sv
// Escape count and colour channel
interface mbe_res_if;
  logic                          valid;
  logic                          ready;
  logic [mbe_pkg::ITER_W-1:0]    iter_count;
  logic [mbe_pkg::COLOR_W-1:0]   red;
  logic [mbe_pkg::COLOR_W-1:0]   green;
  logic [mbe_pkg::COLOR_W-1:0]   blue;

  modport source (output valid, iter_count, red, green, blue, input ready);
  modport sink   (input valid, iter_count, red, green, blue, output ready);
endinterface

FILE: sv/mbe_ctrl.sv
// Sequencer: one pixel at a time, a multiply state and an update state per iteration
module mbe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pix_valid_i,
  output logic             pix_ready_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  input  mbe_pkg::status_t status_i,
  output mbe_pkg::cmd_t    cmd_o
);

  mbe_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  // Result slot empties this cycle or already is empty
  assign slot_free = !out_valid_q || res_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mbe_pkg::ST_IDLE: begin
        if (pix_valid_i) state_d = mbe_pkg::ST_SETUP;
      end
      mbe_pkg::ST_SETUP: begin
        state_d = mbe_pkg::ST_MUL;
      end
      mbe_pkg::ST_MUL: begin
        state_d = status_i.cap_hit ? mbe_pkg::ST_DONE : mbe_pkg::ST_UPD;
      end
      mbe_pkg::ST_UPD: begin
        state_d = status_i.escaped ? mbe_pkg::ST_DONE : mbe_pkg::ST_MUL;
      end
      mbe_pkg::ST_DONE: begin
        if (slot_free) state_d = mbe_pkg::ST_IDLE;
      end
      default: state_d = mbe_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o       = '0;
    pix_ready_o = 1'b0;
    case (state_q)
      mbe_pkg::ST_IDLE: begin
        pix_ready_o    = 1'b1;
        cmd_o.load_pix = pix_valid_i;
      end
      mbe_pkg::ST_SETUP: cmd_o.load_c = 1'b1;
      mbe_pkg::ST_MUL:   cmd_o.mul    = !status_i.cap_hit;
      mbe_pkg::ST_UPD:   cmd_o.upd    = !status_i.escaped;
      mbe_pkg::ST_DONE:  cmd_o.push   = slot_free;
      default: ;
    endcase
  end

  // Result slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign res_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbe_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: sv/mbe_dp.sv
// Datapath: configuration, point setup, z = z*z + c iteration, result register
module mbe_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [mbe_pkg::COORD_BITS-1:0]    pixel_col_i,
  input  logic [mbe_pkg::COORD_BITS-1:0]    pixel_row_i,
  input  mbe_pkg::cmd_t                     cmd_i,
  output mbe_pkg::status_t                  status_o,
  output logic [mbe_pkg::ITER_W-1:0]        iter_count_o,
  output logic [mbe_pkg::COLOR_W-1:0]       red_o,
  output logic [mbe_pkg::COLOR_W-1:0]       green_o,
  output logic [mbe_pkg::COLOR_W-1:0]       blue_o
);

  localparam int CW = mbe_pkg::COORD_W;
  localparam int WW = mbe_pkg::WIDE_W;
  localparam int PW = mbe_pkg::PROD_W;
  localparam int FB = mbe_pkg::FRAC_BITS;

  // Configuration registers
  logic signed [CW-1:0]               x_left_q, y_top_q;
  logic [mbe_pkg::STEP_W-1:0]         step_x_q, step_y_q;
  logic [mbe_pkg::ITER_W-1:0]         max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_left_q   <= mbe_pkg::X_LEFT_RST;
      y_top_q    <= mbe_pkg::Y_TOP_RST;
      step_x_q   <= mbe_pkg::STEP_X_RST;
      step_y_q   <= mbe_pkg::STEP_Y_RST;
      max_iter_q <= mbe_pkg::MAX_ITER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mbe_pkg::CFG_X_LEFT:   x_left_q   <= cfg_data_i[CW-1:0];
        mbe_pkg::CFG_Y_TOP:    y_top_q    <= cfg_data_i[CW-1:0];
        mbe_pkg::CFG_STEP_X:   step_x_q   <= cfg_data_i[mbe_pkg::STEP_W-1:0];
        mbe_pkg::CFG_STEP_Y:   step_y_q   <= cfg_data_i[mbe_pkg::STEP_W-1:0];
        mbe_pkg::CFG_MAX_ITER: max_iter_q <= cfg_data_i[mbe_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  logic [mbe_pkg::COORD_BITS-1:0]     col_q, row_q;
  logic signed [CW-1:0]               c_re_q, c_im_q, x_q, y_q;
  logic signed [PW-1:0]               pxx_q, pyy_q, pxy_q;
  logic [mbe_pkg::ITER_W-1:0]         n_q;
  logic [mbe_pkg::ITER_W-1:0]         iter_count_q;
  logic [3*mbe_pkg::COLOR_W-1:0]      rgb_q;

  // Point setup: c = edge + index * step, saturated
  logic [mbe_pkg::COORD_BITS+mbe_pkg::STEP_W-1:0] off_re, off_im;
  logic signed [WW-1:0]               c_re_wide, c_im_wide;

  assign off_re    = col_q * step_x_q;
  assign off_im    = row_q * step_y_q;
  assign c_re_wide = WW'(x_left_q) + $signed(WW'(off_re));
  assign c_im_wide = WW'(y_top_q)  + $signed(WW'(off_im));

  // Update: floor-shifted products, escape test, next z
  logic signed [PW-FB-1:0]            xx, yy;
  logic signed [PW-FB:0]              xy2;
  logic signed [WW-1:0]               mag, x_wide, y_wide;

  assign xx     = $signed(pxx_q[PW-1:FB]);
  assign yy     = $signed(pyy_q[PW-1:FB]);
  assign xy2    = $signed(pxy_q[PW-1:FB-1]);
  assign mag    = WW'(xx) + WW'(yy);
  assign x_wide = WW'(xx) - WW'(yy) + WW'(c_re_q);
  assign y_wide = WW'(xy2) + WW'(c_im_q);

  assign status_o.escaped = (mag >= mbe_pkg::ESCAPE_LIMIT);
  assign status_o.cap_hit = (n_q >= max_iter_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      col_q <= pixel_col_i;
      row_q <= pixel_row_i;
    end
    if (cmd_i.load_c) begin
      c_re_q <= mbe_pkg::sat32(c_re_wide);
      c_im_q <= mbe_pkg::sat32(c_im_wide);
      x_q    <= '0;
      y_q    <= '0;
      n_q    <= '0;
    end
    if (cmd_i.mul) begin
      pxx_q <= x_q * x_q;
      pyy_q <= y_q * y_q;
      pxy_q <= x_q * y_q;
    end
    if (cmd_i.upd) begin
      x_q <= mbe_pkg::sat32(x_wide);
      y_q <= mbe_pkg::sat32(y_wide);
      n_q <= n_q + 1'b1;
    end
    if (cmd_i.push) begin
      iter_count_q <= n_q;
      rgb_q        <= mbe_pkg::PALETTE[n_q[mbe_pkg::PAL_IDX_W-1:0]];
    end
  end

  assign iter_count_o = iter_count_q;
  assign red_o        = rgb_q[3*mbe_pkg::COLOR_W-1:2*mbe_pkg::COLOR_W];
  assign green_o      = rgb_q[2*mbe_pkg::COLOR_W-1:mbe_pkg::COLOR_W];
  assign blue_o       = rgb_q[mbe_pkg::COLOR_W-1:0];

endmodule

FILE: sv/mandelbrot_escape_time_pixel.sv
// Mandelbrot escape-time evaluator for one pixel per transaction. The point c is
// formed from the pixel column and row and the edge/step registers (signed Q4.28,
// saturating), then z = z*z + c is iterated from zero until |z|^2 reaches 4.0 or
// the count reaches max_iter; the count and its palette colour (count mod 16) are
// returned. One pixel is in flight at a time: after acceptance a setup state
// forms c, then every iteration is a multiply state for x*x, y*y and x*y
// followed by an update state that tests escape and forms the next z; the cap
// is tested in the multiply state. A finished result waits in the output
// register while the next pixel is taken. Configuration registers (0 x_left,
// 1 y_top, 2 step_x, 3 step_y, 4 max_iter) must only be written while the
// block is idle.
module mandelbrot_escape_time_pixel (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mbe_pix_if.sink                        pix_i,
  mbe_res_if.source                      res_o
);

  mbe_pkg::cmd_t    cmd;
  mbe_pkg::status_t status;

  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mbe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_col_i  (pix_i.pixel_col),
    .pixel_row_i  (pix_i.pixel_row),
    .cmd_i        (cmd),
    .status_o     (status),
    .iter_count_o (res_o.iter_count),
    .red_o        (res_o.red),
    .green_o      (res_o.green),
    .blue_o       (res_o.blue)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int      HOLD_CYCLES = 3000;
  localparam int      DRAIN_CYCLES = 20;
  localparam longint  ESCAPE_SQ = 64'sd1073741824;  // 4.0 in Q4.28
  localparam longint  Q_MAX = 64'sd2147483647;
  localparam longint  Q_MIN = -64'sd2147483648;
  localparam longint  ONE_Q = 64'sd268435456;       // 1.0 in Q4.28

  typedef struct packed {
    logic [mbe_pkg::COORD_BITS-1:0] col;
    logic [mbe_pkg::COORD_BITS-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [mbe_pkg::ITER_W-1:0]  iter;
    logic [mbe_pkg::COLOR_W-1:0] red;
    logic [mbe_pkg::COLOR_W-1:0] green;
    logic [mbe_pkg::COLOR_W-1:0] blue;
  } escape_t;

  // Colour table, {red, green, blue}, indexed by count mod 16
  localparam logic [23:0] COLOUR_LUT [16] = '{
    24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
    24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
    24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
    24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data_i;

  mbe_pix_if pix_ch ();
  mbe_res_if res_ch ();

  mandelbrot_escape_time_pixel dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_ch),
    .res_o      (res_ch)
  );

  // Shadow copy of the view registers
  longint      view_x_left;
  longint      view_y_top;
  longint      view_step_x;
  longint      view_step_y;
  int unsigned view_max_iter;

  pixel_t  pixel_q [$];
  escape_t escape_q [$];
  pixel_t  next_pixel;
  escape_t want;

  int n_errors = 0;
  int tx_idle_pct;
  int rx_idle_pct;
  int col_span;
  int row_span;
  bit hold_on = 1'b0;
  event hold_ev;
  logic pix_taken;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint clamp_q428(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Escape count and colour for one pixel under the current view
  function automatic escape_t escape_pixel(input logic [mbe_pkg::COORD_BITS-1:0] col,
                                           input logic [mbe_pkg::COORD_BITS-1:0] row);
    longint      c_re, c_im, zr, zi, rr, ii, ri2;
    int unsigned n;
    escape_t     r;
    c_re = clamp_q428(view_x_left + longint'(col) * view_step_x);
    c_im = clamp_q428(longint'(row) * view_step_y + view_y_top);
    zr = 0;
    zi = 0;
    n = 0;
    while (n < view_max_iter) begin
      rr  = (zr * zr) >>> 28;
      ii  = (zi * zi) >>> 28;
      ri2 = (zr * zi) >>> 27;
      if (rr + ii >= ESCAPE_SQ) break;
      n++;
      zr = clamp_q428(rr - ii + c_re);
      zi = clamp_q428(ri2 + c_im);
    end
    r.iter = n[mbe_pkg::ITER_W-1:0];
    {r.red, r.green, r.blue} = COLOUR_LUT[n % 16];
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Pixel driver: hold the offer until taken, then maybe idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pix_taken) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_pixel = pixel_q.pop_front();
        pix_ch.valid     <= 1'b1;
        pix_ch.pixel_col <= next_pixel.col;
        pix_ch.pixel_row <= next_pixel.row;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // Long sink hold-off, counted in cycles
  always @(hold_ev) begin
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_on = 1'b0;
  end

  // Result sink: random back-pressure, fully held while the hold-off runs
  always @(negedge clk_i) begin
    res_ch.ready <= !hold_on && ($urandom_range(99) >= rx_idle_pct);
  end

  // Monitor: check results first, then predict for a new pixel transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_taken <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (escape_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got count %0d rgb %h%h%h",
                   $time, res_ch.iter_count, res_ch.red, res_ch.green, res_ch.blue);
          n_errors++;
        end else begin
          want = escape_q.pop_front();
          check_field("iter_count", want.iter, res_ch.iter_count);
          check_field("red", want.red, res_ch.red);
          check_field("green", want.green, res_ch.green);
          check_field("blue", want.blue, res_ch.blue);
        end
      end
      if (pix_ch.valid && pix_ch.ready)
        escape_q.push_back(escape_pixel(pix_ch.pixel_col, pix_ch.pixel_row));
      pix_taken <= pix_ch.valid && pix_ch.ready;
    end
  end

  // Register write; the shadow copy follows
  task automatic write_reg(input mbe_pkg::cfg_reg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mbe_pkg::CFG_X_LEFT:   view_x_left   = longint'($signed(val));
      mbe_pkg::CFG_Y_TOP:    view_y_top    = longint'($signed(val));
      mbe_pkg::CFG_STEP_X:   view_step_x   = longint'(val[30:0]);
      mbe_pkg::CFG_STEP_Y:   view_step_y   = longint'(val[30:0]);
      mbe_pkg::CFG_MAX_ITER: view_max_iter = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_view(input logic [31:0] xl, input logic [31:0] yt,
                            input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] mi);
    write_reg(mbe_pkg::CFG_X_LEFT, xl);
    write_reg(mbe_pkg::CFG_Y_TOP, yt);
    write_reg(mbe_pkg::CFG_STEP_X, sx);
    write_reg(mbe_pkg::CFG_STEP_Y, sy);
    write_reg(mbe_pkg::CFG_MAX_ITER, mi);
  endtask

  task automatic add_pixel(input int col, input int row);
    pixel_q.push_back('{col: col[mbe_pkg::COORD_BITS-1:0],
                        row: row[mbe_pkg::COORD_BITS-1:0]});
  endtask

  // Block until every pixel is sent and every result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    while (pixel_q.size() != 0 || pix_ch.valid || escape_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Either a window around the set or wholly random registers
  task automatic random_view();
    logic [31:0] sx, sy, mi;
    if ($urandom_range(3) == 0) begin
      sx = $urandom;
      sy = $urandom;
      write_view($urandom, $urandom, sx, sy, $urandom_range(0, 600));
      col_span = 4095;
      row_span = 4095;
    end else begin
      sx = $urandom_range(1 << 14, 1 << 20);
      sy = $urandom_range(1 << 14, 1 << 20);
      mi = ($urandom_range(7) == 0) ? $urandom_range(1, 600) : $urandom_range(1, 300);
      write_view(-32'sd671088640 + $urandom_range(0, 268435456),
                 -32'sd335544320 + $urandom_range(0, 134217728), sx, sy, mi);
      col_span = (939524096 / sx > 4095) ? 4095 : 939524096 / sx;
      row_span = (671088640 / sy > 4095) ? 4095 : 671088640 / sy;
    end
  endtask

  task automatic random_pixel();
    if ($urandom_range(7) == 0)
      add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
    else
      add_pixel($urandom_range(0, col_span), $urandom_range(0, row_span));
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = mbe_pkg::CFG_X_LEFT;
    cfg_data_i       = '0;
    view_x_left      = -64'sd671088640;
    view_y_top       = -64'sd268435456;
    view_step_x      = 64'sd1468006;
    view_step_y      = 64'sd1118481;
    view_max_iter    = 128;
    tx_idle_pct      = 20;
    rx_idle_pct      = 76;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers at their reset values: corners, centre of the set, edges
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(457, 240);
    add_pixel(0, 240);
    add_pixel(639, 479);
    add_pixel(320, 100);
    wait_drained();

    // Extreme registers: c at the range limits or saturated, cap set to the largest value
    write_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_FFFF);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(1, 0);
    wait_drained();

    // Origin never escapes: runs the full cap of 65535
    write_view(32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF);
    add_pixel(3, 9);
    wait_drained();

    // Cap of zero: no iteration at all
    write_reg(mbe_pkg::CFG_MAX_ITER, 32'h0);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    wait_drained();

    write_reg(mbe_pkg::CFG_MAX_ITER, 32'h1);
    add_pixel(12, 34);
    wait_drained();

    // c = -2: |z|^2 lands exactly on the escape radius
    write_reg(mbe_pkg::CFG_X_LEFT, 32'(-2 * ONE_Q));
    write_reg(mbe_pkg::CFG_MAX_ITER, 32'd16);
    add_pixel(77, 0);
    wait_drained();

    // Random part: three idling profiles, several views each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 20; rx_idle_pct = 76; end
        1: begin tx_idle_pct = 76; rx_idle_pct = 20; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        random_view();
        for (int k = 0; k < 55; k++) random_pixel();
        // Long sink hold-off so the block backs up onto its input
        if (ph == 2 && seg == 0) -> hold_ev;
        wait_drained();
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
